// ===== rtl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler to quaternion converter
// Request payload types, CORDIC lane state and the arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // CORDIC datapath: Q1.30 for x and y, 2^-32 turn for z
  localparam int unsigned CordicIters = 24;
  localparam int unsigned CordicW     = 32;
  localparam int unsigned IterW       = 5;
  localparam int unsigned NumLanes    = 3;
  localparam logic signed [CordicW-1:0] CordicGain = 32'sd652032874;

  // Lane numbering: one lane per angle
  localparam int unsigned LaneRoll  = 0;
  localparam int unsigned LanePitch = 1;
  localparam int unsigned LaneYaw   = 2;

  typedef struct packed {
    logic [15:0] roll_angle;
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
  } e2q_angles_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } e2q_quat_t;

  // One rotator lane: running vector, residual angle and quadrant flag
  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic                      upper;
  } e2q_lane_t;

  typedef e2q_lane_t [NumLanes-1:0] e2q_rot_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CordicW-1:0] e2q_atan(input logic [IterW-1:0] idx);
    logic signed [CordicW-1:0] a;
    case (idx)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/e2q_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// e2q_cordic_cell: one CORDIC rotation step for all three angle lanes
// Holds one request's lane state and hands it to the next cell.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
  parameter int unsigned Iter = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  e2q_pkg::e2q_rot_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output e2q_pkg::e2q_rot_t data_o
);
  import e2q_pkg::*;

  localparam logic signed [CordicW-1:0] Atan = e2q_atan(IterW'(Iter));

  logic     valid_q;
  e2q_rot_t data_d, data_q;

  // Take a new request whenever this cell is empty or is being drained
  assign ready_o = !valid_q || ready_i;

  // Rotate each lane by +/- atan(2^-Iter) toward zero residual
  always_comb begin
    logic signed [CordicW-1:0] dx;
    logic signed [CordicW-1:0] dy;
    data_d = data_i;
    for (int l = 0; l < NumLanes; l++) begin
      dx = data_i[l].y >>> Iter;
      dy = data_i[l].x >>> Iter;
      if (!data_i[l].z[CordicW-1]) begin
        data_d[l].x = data_i[l].x - dx;
        data_d[l].y = data_i[l].y + dy;
        data_d[l].z = data_i[l].z - Atan;
      end else begin
        data_d[l].x = data_i[l].x + dx;
        data_d[l].y = data_i[l].y - dy;
        data_d[l].z = data_i[l].z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload until a new request replaces it
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/e2q_quat_prod.sv =====
// ----------------------------------------------------------------------------
// e2q_quat_prod: half-angle sine/cosine to quaternion
// Rounds the rotator output to Q1.15, forms the triple products over two
// multiplier stages and rounds and saturates the four sums to Q2.14.
// ----------------------------------------------------------------------------
module e2q_quat_prod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  e2q_pkg::e2q_rot_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output e2q_pkg::e2q_quat_t data_o
);
  import e2q_pkg::*;

  localparam int unsigned NumStages = 4;
  localparam int unsigned SW = 18;       // Q1.15 with headroom
  localparam int unsigned PW = 2 * SW;   // pair product
  localparam int unsigned TW = 3 * SW;   // triple product
  localparam int unsigned UW = TW + 1;   // sum of two triples

  // Round Q3.45 to Q2.14 and clamp to 16 bits
  function automatic logic signed [15:0] to_q14(input logic signed [UW-1:0] v);
    logic signed [UW-1:0] r;
    logic signed [15:0]   q;
    r = (v + (UW'(1) << 30)) >>> 31;
    if (r > UW'(32767)) begin
      q = 16'sh7fff;
    end else if (r < -$signed(UW'(32768))) begin
      q = -16'sh8000;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] rdy;

  // Backpressure: a stage loads when empty or when the next one loads
  always_comb begin
    rdy[NumStages-1] = !valid_q[NumStages-1] || ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign ready_o = rdy[0];

  // Stage 0: round Q1.30 to Q1.15 and undo the quadrant fold
  logic signed [SW-1:0] sn_d [NumLanes];
  logic signed [SW-1:0] cs_d [NumLanes];
  logic signed [SW-1:0] sn_q [NumLanes];
  logic signed [SW-1:0] cs_q [NumLanes];

  always_comb begin
    logic signed [CordicW:0] cx;
    logic signed [CordicW:0] sy;
    logic signed [SW-1:0]    c15;
    logic signed [SW-1:0]    s15;
    for (int l = 0; l < NumLanes; l++) begin
      cx  = ($signed({data_i[l].x[CordicW-1], data_i[l].x}) + (CordicW+1)'(16384)) >>> 15;
      sy  = ($signed({data_i[l].y[CordicW-1], data_i[l].y}) + (CordicW+1)'(16384)) >>> 15;
      c15 = cx[SW-1:0];
      s15 = sy[SW-1:0];
      if (data_i[l].upper) begin
        sn_d[l] = c15;
        cs_d[l] = -s15;
      end else begin
        sn_d[l] = s15;
        cs_d[l] = c15;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      sn_q <= sn_d;
      cs_q <= cs_d;
    end
  end

  // Stage 1: pitch by yaw pair products, carry roll terms
  logic signed [PW-1:0] cc_q, ss_q, csy_q, scy_q;
  logic signed [SW-1:0] sr_q, cr_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && valid_q[0]) begin
      cc_q  <= cs_q[LanePitch] * cs_q[LaneYaw];
      ss_q  <= sn_q[LanePitch] * sn_q[LaneYaw];
      csy_q <= cs_q[LanePitch] * sn_q[LaneYaw];
      scy_q <= sn_q[LanePitch] * cs_q[LaneYaw];
      sr_q  <= sn_q[LaneRoll];
      cr_q  <= cs_q[LaneRoll];
    end
  end

  // Stage 2: triple products
  logic signed [TW-1:0] xa_q, xb_q, ya_q, yb_q, za_q, zb_q, wa_q, wb_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && valid_q[1]) begin
      xa_q <= cc_q * sr_q;
      xb_q <= ss_q * cr_q;
      ya_q <= scy_q * cr_q;
      yb_q <= csy_q * sr_q;
      za_q <= csy_q * cr_q;
      zb_q <= scy_q * sr_q;
      wa_q <= cc_q * cr_q;
      wb_q <= ss_q * sr_q;
    end
  end

  // Stage 3: sums, round and saturate into the output register
  e2q_quat_t out_d, out_q;

  always_comb begin
    out_d.quat_x = to_q14(UW'(xa_q) - UW'(xb_q));
    out_d.quat_y = to_q14(UW'(ya_q) + UW'(yb_q));
    out_d.quat_z = to_q14(UW'(za_q) - UW'(zb_q));
    out_d.quat_w = to_q14(UW'(wa_q) + UW'(wb_q));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && valid_q[2]) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q[NumStages-1];
  assign data_o  = out_q;

endmodule

// ===== rtl/euler_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion: roll/pitch/yaw angles to unit rotation quaternion
// A request passes 24 CORDIC cells, then round, two multiplier stages and a
// sum/saturate output register. Throughput: one request per cycle unless
// out_ready_i stalls the output; each cell holds one request.
// Reset clears only the valid bits along the chain; payloads are not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  e2q_pkg::e2q_angles_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output e2q_pkg::e2q_quat_t out_data_o
);
  import e2q_pkg::*;

  e2q_rot_t chain_data  [CordicIters+1];
  logic     chain_valid [CordicIters+1];
  logic     chain_ready [CordicIters+1];
  e2q_rot_t seed;

  logic [15:0] angle [NumLanes];

  assign angle[LaneRoll]  = in_data_i.roll_angle;
  assign angle[LanePitch] = in_data_i.pitch_angle;
  assign angle[LaneYaw]   = in_data_i.yaw_angle;

  // Seed each lane: half angle folded into the first quarter turn
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      seed[l].x     = CordicGain;
      seed[l].y     = '0;
      seed[l].z     = {2'b00, angle[l][14:0], 15'b0};
      seed[l].upper = angle[l][15];
    end
  end

  assign chain_data[0]  = seed;
  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  // Row of rotation cells
  for (genvar i = 0; i < CordicIters; i++) begin : g_cell
    e2q_cordic_cell #(
      .Iter(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_valid[i]),
      .ready_o(chain_ready[i]),
      .data_i (chain_data[i]),
      .valid_o(chain_valid[i+1]),
      .ready_i(chain_ready[i+1]),
      .data_o (chain_data[i+1])
    );
  end

  e2q_quat_prod u_prod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(chain_valid[CordicIters]),
    .ready_o(chain_ready[CordicIters]),
    .data_i (chain_data[CordicIters]),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule
